>>> design/oan_pkg.sv
// Package for the obstacle-avoidance navigation block: codes, widths and word types.
// No dependencies; every other design file refers to it by scoped names.
package oan_pkg;

  localparam int DIST_W  = 10;
  localparam int MS_W    = 16;
  localparam int TIME_W  = 32;
  localparam int COLOR_W = 3;
  localparam int MOTOR_W = 3;
  localparam int BRUSH_W = 2;
  localparam int NAV_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;

  // Motor commands
  localparam logic [MOTOR_W-1:0] MOT_HOLD  = 3'd0;
  localparam logic [MOTOR_W-1:0] MOT_STOP  = 3'd1;
  localparam logic [MOTOR_W-1:0] MOT_FWD   = 3'd2;
  localparam logic [MOTOR_W-1:0] MOT_LEFT  = 3'd3;
  localparam logic [MOTOR_W-1:0] MOT_RIGHT = 3'd4;
  localparam logic [MOTOR_W-1:0] MOT_REV   = 3'd5;

  // Brush commands
  localparam logic [BRUSH_W-1:0] BR_HOLD  = 2'd0;
  localparam logic [BRUSH_W-1:0] BR_STOP  = 2'd1;
  localparam logic [BRUSH_W-1:0] BR_START = 2'd2;

  // Navigation states
  localparam logic [NAV_W-1:0] NV_FWD   = 3'd0;
  localparam logic [NAV_W-1:0] NV_COLL  = 3'd1;
  localparam logic [NAV_W-1:0] NV_LEFT  = 3'd2;
  localparam logic [NAV_W-1:0] NV_RIGHT = 3'd3;
  localparam logic [NAV_W-1:0] NV_REV   = 3'd4;

  // Floor colour classes
  localparam logic [COLOR_W-1:0] COL_BLUE  = 3'd0;
  localparam logic [COLOR_W-1:0] COL_RED   = 3'd1;
  localparam logic [COLOR_W-1:0] COL_BLACK = 3'd2;

  // Drive modes
  localparam logic MODE_MANUAL = 1'b0;
  localparam logic MODE_AUTO   = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_FRONT_LIMIT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_RIGHT_CLEAR = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LEFT_CLEAR  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LEFT_TURN   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RIGHT_TURN  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_REVERSE     = 3'd5;

  typedef struct packed {
    logic               button_down;
    logic [COLOR_W-1:0] floor_color;
    logic [DIST_W-1:0]  front_distance;
    logic [DIST_W-1:0]  right_dist_cm;
    logic [DIST_W-1:0]  left_dist_cm;
    logic               try_right_first;
    logic [TIME_W-1:0]  now_ms;
  } tick_word_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor_cmd;
    logic [BRUSH_W-1:0] brush_cmd;
    logic               mode_out;
    logic [NAV_W-1:0]   nav_state_out;
  } cmd_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] front_limit_cm;
    logic [DIST_W-1:0] right_clear_cm;
    logic [DIST_W-1:0] left_clear_cm;
    logic [MS_W-1:0]   left_turn_ms;
    logic [MS_W-1:0]   right_turn_ms;
    logic [MS_W-1:0]   reverse_ms;
  } cfg_t;

endpackage

>>> design/oan_tick_if.sv
// Input channel carrying one control tick word.
// Depends on oan_pkg for field widths.
interface oan_tick_if;
  logic                        valid;
  logic                        ready;
  logic                        button_down;
  logic [oan_pkg::COLOR_W-1:0] floor_color;
  logic [oan_pkg::DIST_W-1:0]  front_distance;
  logic [oan_pkg::DIST_W-1:0]  right_dist_cm;
  logic [oan_pkg::DIST_W-1:0]  left_dist_cm;
  logic                        try_right_first;
  logic [oan_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, button_down, floor_color, front_distance, right_dist_cm,
                  left_dist_cm, try_right_first, now_ms, input ready);
  modport sink (input valid, button_down, floor_color, front_distance, right_dist_cm,
                left_dist_cm, try_right_first, now_ms, output ready);
endinterface

>>> design/oan_cmd_if.sv
// Output channel carrying one motor/brush command word.
// Depends on oan_pkg for field widths.
interface oan_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [oan_pkg::MOTOR_W-1:0] motor_cmd;
  logic [oan_pkg::BRUSH_W-1:0] brush_cmd;
  logic                        mode_out;
  logic [oan_pkg::NAV_W-1:0]   nav_state_out;

  modport source (output valid, motor_cmd, brush_cmd, mode_out, nav_state_out, input ready);
  modport sink (input valid, motor_cmd, brush_cmd, mode_out, nav_state_out, output ready);
endinterface

>>> design/oan_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on oan_pkg for field widths.
interface oan_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [oan_pkg::CIDX_W-1:0] index;
  logic [oan_pkg::CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/oan_cfg_regs.sv
// Configuration register bank for the navigation block.
// Depends on oan_pkg and oan_cfg_if.
module oan_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  oan_cfg_if.sink       cfg,
  output oan_pkg::cfg_t regs
);

  // Always take a write; unknown indexes drop the word
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.front_limit_cm <= oan_pkg::DIST_W'(20);
      regs.right_clear_cm <= oan_pkg::DIST_W'(20);
      regs.left_clear_cm  <= oan_pkg::DIST_W'(20);
      regs.left_turn_ms   <= oan_pkg::MS_W'(500);
      regs.right_turn_ms  <= oan_pkg::MS_W'(500);
      regs.reverse_ms     <= oan_pkg::MS_W'(800);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        oan_pkg::REG_FRONT_LIMIT: regs.front_limit_cm <= cfg.data[oan_pkg::DIST_W-1:0];
        oan_pkg::REG_RIGHT_CLEAR: regs.right_clear_cm <= cfg.data[oan_pkg::DIST_W-1:0];
        oan_pkg::REG_LEFT_CLEAR:  regs.left_clear_cm  <= cfg.data[oan_pkg::DIST_W-1:0];
        oan_pkg::REG_LEFT_TURN:   regs.left_turn_ms   <= cfg.data[oan_pkg::MS_W-1:0];
        oan_pkg::REG_RIGHT_TURN:  regs.right_turn_ms  <= cfg.data[oan_pkg::MS_W-1:0];
        oan_pkg::REG_REVERSE:     regs.reverse_ms     <= cfg.data[oan_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/oan_nav_core.sv
// Navigation state and per-tick decision logic: mode, state machine, phase timer.
// Depends on oan_pkg; the state updates when the top level advances a word.
module oan_nav_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  oan_pkg::tick_word_t tick,
  input  oan_pkg::cfg_t      regs,
  output oan_pkg::cmd_word_t cmd
);

  logic                        prev_button;
  logic                        drive_mode;
  logic [oan_pkg::NAV_W-1:0]   nav_state;
  logic [oan_pkg::TIME_W-1:0]  phase_start_ms;

  logic                        drive_mode_next;
  logic [oan_pkg::NAV_W-1:0]   nav_state_next;
  logic [oan_pkg::TIME_W-1:0]  phase_start_ms_next;
  logic [oan_pkg::MOTOR_W-1:0] motor;
  logic [oan_pkg::BRUSH_W-1:0] brush;
  logic [oan_pkg::TIME_W-1:0]  elapsed;
  logic                        press;
  logic                        right_ok;
  logic                        left_ok;
  logic                        go_right;

  assign elapsed  = tick.now_ms - phase_start_ms;
  assign press    = !prev_button && tick.button_down;
  assign right_ok = tick.right_dist_cm > regs.right_clear_cm;
  assign left_ok  = tick.left_dist_cm > regs.left_clear_cm;
  assign go_right = tick.try_right_first ? right_ok : (!left_ok && right_ok);

  // Decide commands and next state for the word in the input register
  always_comb begin
    motor               = oan_pkg::MOT_HOLD;
    brush               = oan_pkg::BR_HOLD;
    drive_mode_next     = drive_mode;
    nav_state_next      = nav_state;
    phase_start_ms_next = phase_start_ms;
    if (drive_mode == oan_pkg::MODE_MANUAL) begin
      if (press) begin
        drive_mode_next = oan_pkg::MODE_AUTO;
      end
    end else if (press || tick.floor_color == oan_pkg::COL_BLUE) begin
      motor           = oan_pkg::MOT_STOP;
      brush           = oan_pkg::BR_STOP;
      drive_mode_next = oan_pkg::MODE_MANUAL;
      nav_state_next  = oan_pkg::NV_FWD;
    end else if (tick.floor_color == oan_pkg::COL_BLACK && nav_state != oan_pkg::NV_REV) begin
      motor               = oan_pkg::MOT_STOP;
      brush               = oan_pkg::BR_STOP;
      nav_state_next      = oan_pkg::NV_REV;
      phase_start_ms_next = tick.now_ms;
    end else begin
      brush = (tick.floor_color == oan_pkg::COL_RED) ? oan_pkg::BR_START : oan_pkg::BR_STOP;
      unique case (nav_state)
        oan_pkg::NV_FWD: begin
          motor = oan_pkg::MOT_FWD;
          if (tick.front_distance < regs.front_limit_cm) begin
            motor          = oan_pkg::MOT_STOP;
            nav_state_next = oan_pkg::NV_COLL;
          end
        end
        oan_pkg::NV_COLL: begin
          phase_start_ms_next = tick.now_ms;
          if (go_right) begin
            motor          = oan_pkg::MOT_RIGHT;
            nav_state_next = oan_pkg::NV_RIGHT;
          end else if (left_ok) begin
            motor          = oan_pkg::MOT_LEFT;
            nav_state_next = oan_pkg::NV_LEFT;
          end else begin
            motor          = oan_pkg::MOT_REV;
            nav_state_next = oan_pkg::NV_REV;
          end
        end
        oan_pkg::NV_LEFT: begin
          motor = oan_pkg::MOT_LEFT;
          if (elapsed > {16'b0, regs.left_turn_ms}) begin
            motor          = oan_pkg::MOT_STOP;
            nav_state_next = oan_pkg::NV_FWD;
          end
        end
        oan_pkg::NV_RIGHT: begin
          motor = oan_pkg::MOT_RIGHT;
          if (elapsed > {16'b0, regs.right_turn_ms}) begin
            motor          = oan_pkg::MOT_STOP;
            nav_state_next = oan_pkg::NV_FWD;
          end
        end
        oan_pkg::NV_REV: begin
          motor = oan_pkg::MOT_REV;
          if (elapsed > {16'b0, regs.reverse_ms}) begin
            motor          = oan_pkg::MOT_STOP;
            nav_state_next = oan_pkg::NV_COLL;
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd.motor_cmd     = motor;
  assign cmd.brush_cmd     = brush;
  assign cmd.mode_out      = drive_mode_next;
  assign cmd.nav_state_out = nav_state_next;

  // Commit state when the word moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_button    <= 1'b0;
      drive_mode     <= oan_pkg::MODE_AUTO;
      nav_state      <= oan_pkg::NV_FWD;
      phase_start_ms <= '0;
    end else if (advance) begin
      prev_button    <= tick.button_down;
      drive_mode     <= drive_mode_next;
      nav_state      <= nav_state_next;
      phase_start_ms <= phase_start_ms_next;
    end
  end

endmodule

>>> design/obstacle_avoid_nav_fsm_core.sv
// Top level of the obstacle-avoidance navigation block: input and result registers.
// Depends on oan_pkg, the channel interfaces, oan_cfg_regs and oan_nav_core.
//
//   channel  dir  word                                       handshake
//   tick     in   button, colour, three distances, rnd, time valid/ready
//   cmd      out  motor, brush, mode, nav state              valid/ready
//   cfg      in   register index, write data                 valid/ready (always ready)
//
// One word per cycle sustained while cmd is ready; each tick word is held in the input register,
// then goes through one pass of the decision logic into the result register.
// Reset (rst, synchronous) empties both registers and restores state and registers.
// A stalled result holds its word; the input register still takes one more word.
module obstacle_avoid_nav_fsm_core (
  input  logic      clk,
  input  logic      rst,
  oan_tick_if.sink  tick,
  oan_cmd_if.source cmd,
  oan_cfg_if.sink   cfg
);

  oan_pkg::cfg_t      regs;
  oan_pkg::tick_word_t in_word;
  oan_pkg::cmd_word_t res_word;
  oan_pkg::cmd_word_t out_word;
  logic               in_valid;
  logic               out_valid;
  logic               advance;
  logic               tick_take;

  oan_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  oan_nav_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (in_word),
    .regs    (regs),
    .cmd     (res_word)
  );

  // Move the held word on whenever the result register is free or draining
  assign advance    = in_valid && (!out_valid || cmd.ready);
  assign tick.ready = !in_valid || advance;
  assign tick_take  = tick.valid && tick.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      in_word.button_down     <= tick.button_down;
      in_word.floor_color     <= tick.floor_color;
      in_word.front_distance  <= tick.front_distance;
      in_word.right_dist_cm   <= tick.right_dist_cm;
      in_word.left_dist_cm    <= tick.left_dist_cm;
      in_word.try_right_first <= tick.try_right_first;
      in_word.now_ms          <= tick.now_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res_word;
    end
  end

  assign cmd.valid         = out_valid;
  assign cmd.motor_cmd     = out_word.motor_cmd;
  assign cmd.brush_cmd     = out_word.brush_cmd;
  assign cmd.mode_out      = out_word.mode_out;
  assign cmd.nav_state_out = out_word.nav_state_out;

  // A word taken while the input register cannot drain must still be held next cycle
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (tick_take && !advance) |=> in_valid)
    else $error("input word lost");

  // A word that advances always appears as a result
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word not presented");

  // An empty input register never refuses a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> tick.ready)
    else $error("empty input register stalls");

  // Manual mode always leaves navigation at forward
  a_manual_fwd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.mode_out == oan_pkg::MODE_MANUAL) |->
      (out_word.nav_state_out == oan_pkg::NV_FWD))
    else $error("manual mode with navigation active");

endmodule

>>> tb/tb_obstacle_avoid_nav_fsm_core.sv
// Testbench for obstacle_avoid_nav_fsm_core: directed ticks, then random ticks under several
// register settings, each command word checked against a typed expectation or a behavioural navigation predictor.
// Depends on oan_pkg, the tick/cmd/cfg channel interfaces and the design sources.
`timescale 1ns / 1ps

module tb_obstacle_avoid_nav_fsm_core;
  import oan_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int HOLD_CYCLES  = 80;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int MAX_REPORTS  = 40;

  // Colour classes and register slots the package leaves unnamed
  localparam logic [COLOR_W-1:0] COL_WHITE = 3'd3;
  localparam logic [COLOR_W-1:0] COL_OTHER = 3'd4;
  localparam logic [CIDX_W-1:0]  REG_SPARE_6 = 3'd6;
  localparam logic [CIDX_W-1:0]  REG_SPARE_7 = 3'd7;

  typedef struct {
    tick_word_t w;
    bit         typed;
    cmd_word_t  want;
  } dir_row_t;

  logic clk;
  logic rst;

  oan_tick_if tick_ch ();
  oan_cmd_if  cmd_ch ();
  oan_cfg_if  cfg_ch ();

  obstacle_avoid_nav_fsm_core u_top (
    .clk (clk),
    .rst (rst),
    .tick(tick_ch),
    .cmd (cmd_ch),
    .cfg (cfg_ch)
  );

  // Predictor state and register copy
  logic              pb_level;
  logic              drv_mode;
  logic [NAV_W-1:0]  nav_st;
  logic [TIME_W-1:0] phase_t0;
  cfg_t              cur_cfg;

  cmd_word_t   pending_cmds[$];
  dir_row_t    dir_rows[$];
  int unsigned err_cnt;
  int unsigned n_ticks;
  int unsigned n_checked;
  int unsigned n_writes;
  int unsigned n_settings;
  bit          long_hold_req;
  bit          tx_burst;
  logic [TIME_W-1:0] run_ms;
  logic        btn_lvl;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Work out the command word one tick produces and advance the predictor state
  function automatic cmd_word_t nav_step_cmd(input tick_word_t w);
    cmd_word_t         r;
    logic [TIME_W-1:0] dt;
    logic              press;
    logic              r_ok;
    logic              l_ok;
    r.motor_cmd = MOT_HOLD;
    r.brush_cmd = BR_HOLD;
    dt    = w.now_ms - phase_t0;
    press = !pb_level && w.button_down;
    pb_level = w.button_down;
    if (drv_mode == MODE_MANUAL) begin
      if (press) drv_mode = MODE_AUTO;
    end else if (press || w.floor_color == COL_BLUE) begin
      r.motor_cmd = MOT_STOP;
      r.brush_cmd = BR_STOP;
      drv_mode    = MODE_MANUAL;
      nav_st      = NV_FWD;
    end else if (w.floor_color == COL_BLACK && nav_st != NV_REV) begin
      r.motor_cmd = MOT_STOP;
      r.brush_cmd = BR_STOP;
      nav_st      = NV_REV;
      phase_t0    = w.now_ms;
    end else begin
      r_ok = w.right_dist_cm > cur_cfg.right_clear_cm;
      l_ok = w.left_dist_cm > cur_cfg.left_clear_cm;
      r.brush_cmd = (w.floor_color == COL_RED) ? BR_START : BR_STOP;
      case (nav_st)
        NV_FWD: begin
          r.motor_cmd = MOT_FWD;
          if (w.front_distance < cur_cfg.front_limit_cm) begin
            r.motor_cmd = MOT_STOP;
            nav_st      = NV_COLL;
          end
        end
        NV_COLL: begin
          phase_t0 = w.now_ms;
          if (w.try_right_first ? r_ok : (!l_ok && r_ok)) begin
            r.motor_cmd = MOT_RIGHT;
            nav_st      = NV_RIGHT;
          end else if (l_ok) begin
            r.motor_cmd = MOT_LEFT;
            nav_st      = NV_LEFT;
          end else begin
            r.motor_cmd = MOT_REV;
            nav_st      = NV_REV;
          end
        end
        NV_LEFT: begin
          r.motor_cmd = MOT_LEFT;
          if (dt > TIME_W'(cur_cfg.left_turn_ms)) begin
            r.motor_cmd = MOT_STOP;
            nav_st      = NV_FWD;
          end
        end
        NV_RIGHT: begin
          r.motor_cmd = MOT_RIGHT;
          if (dt > TIME_W'(cur_cfg.right_turn_ms)) begin
            r.motor_cmd = MOT_STOP;
            nav_st      = NV_FWD;
          end
        end
        NV_REV: begin
          r.motor_cmd = MOT_REV;
          if (dt > TIME_W'(cur_cfg.reverse_ms)) begin
            r.motor_cmd = MOT_STOP;
            nav_st      = NV_COLL;
          end
        end
        default: ;
      endcase
    end
    r.mode_out      = drv_mode;
    r.nav_state_out = nav_st;
    return r;
  endfunction

  // Mirror one register write; wide data is cut to the register's width
  function automatic void cfg_apply(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] d);
    case (idx)
      REG_FRONT_LIMIT: cur_cfg.front_limit_cm = d[DIST_W-1:0];
      REG_RIGHT_CLEAR: cur_cfg.right_clear_cm = d[DIST_W-1:0];
      REG_LEFT_CLEAR:  cur_cfg.left_clear_cm  = d[DIST_W-1:0];
      REG_LEFT_TURN:   cur_cfg.left_turn_ms   = d[MS_W-1:0];
      REG_RIGHT_TURN:  cur_cfg.right_turn_ms  = d[MS_W-1:0];
      REG_REVERSE:     cur_cfg.reverse_ms     = d[MS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic tick_word_t tick_of(input logic btn, input logic [COLOR_W-1:0] col,
                                         input int f, input int rt, input int lt,
                                         input logic rf, input logic [TIME_W-1:0] t);
    tick_word_t w;
    w.button_down     = btn;
    w.floor_color     = col;
    w.front_distance  = DIST_W'(f);
    w.right_dist_cm   = DIST_W'(rt);
    w.left_dist_cm    = DIST_W'(lt);
    w.try_right_first = rf;
    w.now_ms          = t;
    return w;
  endfunction

  function automatic cmd_word_t cmd_of(input logic [MOTOR_W-1:0] m, input logic [BRUSH_W-1:0] b,
                                       input logic md, input logic [NAV_W-1:0] nv);
    cmd_word_t c;
    c.motor_cmd     = m;
    c.brush_cmd     = b;
    c.mode_out      = md;
    c.nav_state_out = nv;
    return c;
  endfunction

  // Distance biased towards its threshold and the ends of the range
  function automatic int pick_dist(input logic [DIST_W-1:0] thr);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'(thr) + int'($urandom_range(0, 2)) - 1;
      3:       v = 0;
      4:       v = 1023;
      5:       v = $urandom_range(0, thr);
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic add_row(input tick_word_t w, input bit typed, input cmd_word_t want);
    dir_row_t row;
    row.w     = w;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Offer one tick word after an idle gap; hold it until taken, then queue its command
  task automatic send_tick(input tick_word_t w, input int gap, input bit use_want,
                           input cmd_word_t want);
    cmd_word_t pred;
    @(negedge clk);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.button_down     <= w.button_down;
    tick_ch.floor_color     <= w.floor_color;
    tick_ch.front_distance  <= w.front_distance;
    tick_ch.right_dist_cm   <= w.right_dist_cm;
    tick_ch.left_dist_cm    <= w.left_dist_cm;
    tick_ch.try_right_first <= w.try_right_first;
    tick_ch.now_ms          <= w.now_ms;
    tick_ch.valid           <= 1'b1;
    do @(posedge clk); while (!tick_ch.ready);
    pred = nav_step_cmd(w);
    pending_cmds.push_back(use_want ? want : pred);
    n_ticks++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] d);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_apply(idx, d);
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued command has come back, then let the pipeline settle
  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register setting, then a run of random ticks
  task automatic run_setting(input logic [CDAT_W-1:0] s_front, input logic [CDAT_W-1:0] s_right,
                             input logic [CDAT_W-1:0] s_left, input logic [CDAT_W-1:0] s_lt,
                             input logic [CDAT_W-1:0] s_rt, input logic [CDAT_W-1:0] s_rev,
                             input logic [TIME_W-1:0] t_start, input bit pressure);
    tick_word_t  w;
    logic [95:0] rnd_bits;
    int unsigned lim;
    int unsigned k;
    int          gap;
    int          burst_left;
    drain();
    write_reg(n_settings[0] ? REG_SPARE_7 : REG_SPARE_6, CDAT_W'($urandom));
    write_reg(REG_FRONT_LIMIT, s_front);
    write_reg(REG_RIGHT_CLEAR, s_right);
    write_reg(REG_LEFT_CLEAR, s_left);
    write_reg(REG_LEFT_TURN, s_lt);
    write_reg(REG_RIGHT_TURN, s_rt);
    write_reg(REG_REVERSE, s_rev);
    n_settings++;
    run_ms     = t_start;
    burst_left = 0;
    for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
      // Fill the block while the receiver holds off
      if (pressure && i == 40) begin
        long_hold_req = 1'b1;
        burst_left    = 30;
      end
      if ($urandom_range(0, 29) == 0) tx_burst = ~tx_burst;

      case (nav_st)
        NV_LEFT:  lim = cur_cfg.left_turn_ms;
        NV_RIGHT: lim = cur_cfg.right_turn_ms;
        default:  lim = cur_cfg.reverse_ms;
      endcase
      if ($urandom_range(0, 11) == 0) begin
        // Noise: every field random
        rnd_bits = {$urandom, $urandom, $urandom};
        w        = rnd_bits[$bits(tick_word_t)-1:0];
        run_ms   = w.now_ms;
        btn_lvl  = w.button_down;
      end else begin
        // Advance the clock, now and then landing on the end of a timed phase
        if ((nav_st == NV_LEFT || nav_st == NV_RIGHT || nav_st == NV_REV) &&
            $urandom_range(0, 7) == 0)
          run_ms = phase_t0 + lim + $urandom_range(0, 1);
        else
          run_ms = run_ms + $urandom_range(0, lim / 8 + 8);
        if ($urandom_range(0, 99) < ((drv_mode == MODE_MANUAL) ? 35 : 3)) btn_lvl = ~btn_lvl;
        k = $urandom_range(0, 99);
        if (k < 3)       w.floor_color = COL_BLUE;
        else if (k < 9)  w.floor_color = COL_BLACK;
        else if (k < 25) w.floor_color = COL_RED;
        else if (k < 30) w.floor_color = COLOR_W'($urandom_range(5, 7));
        else if (k < 65) w.floor_color = COL_WHITE;
        else             w.floor_color = COL_OTHER;
        w.button_down     = btn_lvl;
        w.front_distance  = DIST_W'(pick_dist(cur_cfg.front_limit_cm));
        w.right_dist_cm   = DIST_W'(pick_dist(cur_cfg.right_clear_cm));
        w.left_dist_cm    = DIST_W'(pick_dist(cur_cfg.left_clear_cm));
        w.try_right_first = 1'($urandom_range(0, 1));
        w.now_ms          = run_ms;
      end

      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = tx_burst ? 0 : $urandom_range(0, 11);
      end
      send_tick(w, gap, 1'b0, '0);
    end
    @(negedge clk);
    tick_ch.valid <= 1'b0;
  endtask

  task automatic report(input string field, input int want, input int got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t ns: %s mismatch on word %0d: expected %0d, got %0d",
               $time, field, n_checked, want, got);
  endtask

  // Receiver: random stalls, one long hold-off on request, compare every word
  initial begin
    bit        rx_burst;
    int        n;
    cmd_word_t want;
    cmd_ch.ready = 1'b0;
    rx_burst     = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = ~rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, 11);
      if (long_hold_req) begin
        n = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      cmd_ch.ready <= 1'b1;
      do @(posedge clk); while (!cmd_ch.valid);
      if (pending_cmds.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t ns: unrequested command word: expected none, got motor %0d brush %0d",
                   $time, cmd_ch.motor_cmd, cmd_ch.brush_cmd);
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_ch.motor_cmd !== want.motor_cmd)
          report("motor_cmd", want.motor_cmd, cmd_ch.motor_cmd);
        if (cmd_ch.brush_cmd !== want.brush_cmd)
          report("brush_cmd", want.brush_cmd, cmd_ch.brush_cmd);
        if (cmd_ch.mode_out !== want.mode_out)
          report("mode_out", want.mode_out, cmd_ch.mode_out);
        if (cmd_ch.nav_state_out !== want.nav_state_out)
          report("nav_state_out", want.nav_state_out, cmd_ch.nav_state_out);
      end
      n_checked++;
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles with %0d words outstanding",
             LIMIT_CYCLES, pending_cmds.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    tick_ch.valid           = 1'b0;
    tick_ch.button_down     = 1'b0;
    tick_ch.floor_color     = '0;
    tick_ch.front_distance  = '0;
    tick_ch.right_dist_cm   = '0;
    tick_ch.left_dist_cm    = '0;
    tick_ch.try_right_first = 1'b0;
    tick_ch.now_ms          = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    err_cnt = 0;
    n_ticks = 0;
    n_checked = 0;
    n_writes = 0;
    n_settings = 0;
    long_hold_req = 1'b0;
    tx_burst = 1'b0;
    btn_lvl  = 1'b0;

    // Predictor starts from the reset state
    pb_level = 1'b0;
    drv_mode = MODE_AUTO;
    nav_st   = NV_FWD;
    phase_t0 = '0;
    cur_cfg.front_limit_cm = 10'd20;
    cur_cfg.right_clear_cm = 10'd20;
    cur_cfg.left_clear_cm  = 10'd20;
    cur_cfg.left_turn_ms   = 16'd500;
    cur_cfg.right_turn_ms  = 16'd500;
    cur_cfg.reverse_ms     = 16'd800;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks under reset register values
    //       btn  colour     front right left rf  now
    add_row(tick_of(0, COL_WHITE, 1023, 0, 0, 0, 0), 1,
            cmd_of(MOT_FWD, BR_STOP, MODE_AUTO, NV_FWD));
    // front exactly at the limit is no collision
    add_row(tick_of(0, COL_RED, 20, 0, 0, 0, 10), 1,
            cmd_of(MOT_FWD, BR_START, MODE_AUTO, NV_FWD));
    add_row(tick_of(0, COL_WHITE, 19, 0, 0, 0, 20), 1,
            cmd_of(MOT_STOP, BR_STOP, MODE_AUTO, NV_COLL));
    add_row(tick_of(0, COL_RED, 0, 21, 21, 1, 100), 1,
            cmd_of(MOT_RIGHT, BR_START, MODE_AUTO, NV_RIGHT));
    // turn lasts while elapsed equals its limit, ends one past it
    add_row(tick_of(0, COL_WHITE, 0, 0, 0, 0, 600), 1,
            cmd_of(MOT_RIGHT, BR_STOP, MODE_AUTO, NV_RIGHT));
    add_row(tick_of(0, COL_WHITE, 0, 0, 0, 0, 601), 1,
            cmd_of(MOT_STOP, BR_STOP, MODE_AUTO, NV_FWD));
    add_row(tick_of(0, COL_OTHER, 0, 0, 0, 0, 700), 0, '0);
    add_row(tick_of(0, COL_OTHER, 1023, 1023, 1023, 0, 1000), 0, '0);
    add_row(tick_of(0, COL_OTHER, 1023, 0, 0, 0, 1501), 0, '0);
    add_row(tick_of(0, COL_WHITE, 0, 0, 0, 0, 1600), 0, '0);
    add_row(tick_of(0, COL_WHITE, 0, 21, 20, 0, 2000), 0, '0);
    // black floor forces reverse and restarts the timer
    add_row(tick_of(0, COL_BLACK, 1023, 0, 0, 0, 2100), 1,
            cmd_of(MOT_STOP, BR_STOP, MODE_AUTO, NV_REV));
    add_row(tick_of(0, COL_BLACK, 1023, 0, 0, 0, 2200), 0, '0);
    // press edge in automatic drops to manual
    add_row(tick_of(1, COL_WHITE, 1023, 0, 0, 0, 2300), 1,
            cmd_of(MOT_STOP, BR_STOP, MODE_MANUAL, NV_FWD));
    add_row(tick_of(1, COL_WHITE, 1023, 0, 0, 0, 2400), 1,
            cmd_of(MOT_HOLD, BR_HOLD, MODE_MANUAL, NV_FWD));
    add_row(tick_of(0, COL_BLUE, 1023, 0, 0, 0, 2500), 0, '0);
    add_row(tick_of(1, 3'd7, 1023, 0, 0, 0, 2600), 1,
            cmd_of(MOT_HOLD, BR_HOLD, MODE_AUTO, NV_FWD));
    // blue floor with the button held
    add_row(tick_of(1, COL_BLUE, 1023, 0, 0, 0, 2700), 0, '0);
    add_row(tick_of(0, 3'd6, 1023, 0, 0, 0, 2800), 0, '0);
    add_row(tick_of(1, 3'd5, 1023, 0, 0, 0, 2900), 0, '0);
    add_row(tick_of(1, 3'd7, 1023, 0, 0, 0, 3000), 0, '0);
    add_row(tick_of(1, COL_WHITE, 0, 1023, 1023, 0, 3100), 0, '0);
    // no clear side: reverse across the 32-bit wrap of the clock
    add_row(tick_of(1, COL_OTHER, 0, 0, 0, 1, 32'hFFFF_FFF0), 0, '0);
    add_row(tick_of(1, COL_OTHER, 0, 0, 0, 1, 32'h0000_0310), 0, '0);
    add_row(tick_of(1, COL_OTHER, 0, 0, 0, 1, 32'h0000_0311), 0, '0);
    add_row(tick_of(0, COL_OTHER, 1023, 1023, 1023, 1, 32'hFFFF_FFFF), 0, '0);

    foreach (dir_rows[i])
      send_tick(dir_rows[i].w, $urandom_range(0, 11), dir_rows[i].typed, dir_rows[i].want);
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    btn_lvl = pb_level;

    // Random ticks under several settings, extremes among them
    run_setting(16'd30, 16'd40, 16'd40, 16'd300, 16'd200, 16'd400, $urandom, 1'b1);
    run_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_F000, 1'b0);
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom, 1'b0);
    run_setting(CDAT_W'($urandom), CDAT_W'($urandom), CDAT_W'($urandom),
                CDAT_W'($urandom_range(0, 65535)), CDAT_W'($urandom_range(0, 2000)),
                CDAT_W'($urandom_range(0, 65535)), $urandom, 1'b0);
    // upper data bits set on the distance registers must be dropped
    run_setting(16'hFC14, 16'h7C32, 16'hA80A, 16'd1, 16'd50, 16'd120, $urandom, 1'b0);

    drain();
    $display("Ran %0d ticks (%0d directed) over %0d register settings with %0d writes",
             n_ticks, dir_rows.size(), n_settings, n_writes);
    $display("Checked %0d command words, %0d field mismatches", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
